// ===== rtl/core/coh_pkg.sv =====
// ----------------------------------------------------------------------------
// coh_pkg: shared types and constants of the coherence node controller
// Field widths, operation and result codes, and the packed result beat.
// ----------------------------------------------------------------------------
package coh_pkg;

	localparam int MODE_W  = 3;
	localparam int BLOCK_W = 3;
	localparam int VALUE_W = 32;
	localparam int NODE_W  = 3;
	localparam int KIND_W  = 2;
	localparam int MSG_W   = 2;

	localparam int IN_FIELDS_W  = BLOCK_W + VALUE_W + NODE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = NODE_W + BLOCK_W + VALUE_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;
	localparam int OUT_TUSER_W  = KIND_W + MSG_W;

	localparam logic [NODE_W-1:0] RESET_OWNER = NODE_W'(1);
	localparam logic [NODE_W-1:0] RESET_NODE  = NODE_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_READ      = 3'd0,
		MODE_WRITE     = 3'd1,
		MODE_INVAL     = 3'd2,
		MODE_FETCH_REQ = 3'd3,
		MODE_FETCH_RSP = 3'd4,
		MODE_CLAIM     = 3'd5
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MSG        = 2'd0,
		KIND_READ_DONE  = 2'd1,
		KIND_WRITE_DONE = 2'd2
	} kind_t;

	typedef enum logic [MSG_W-1:0] {
		MSG_INVAL     = 2'd0,
		MSG_FETCH_REQ = 2'd1,
		MSG_FETCH_RSP = 2'd2,
		MSG_CLAIM     = 2'd3
	} msg_t;

	typedef enum logic [2:0] {
		SEQ_INVAL = 3'b001,
		SEQ_CLAIM = 3'b010,
		SEQ_LAST  = 3'b100
	} seq_t;

	typedef struct packed {
		kind_t               kind;
		msg_t                msg;
		logic [NODE_W-1:0]   dest;
		logic [BLOCK_W-1:0]  blk;
		logic [VALUE_W-1:0]  value;
		logic                last;
	} result_t;

endpackage

// ===== rtl/core/coherence_node_controller.sv =====
// ----------------------------------------------------------------------------
// coherence_node_controller: one node of an owner-directory coherence scheme
// Path: an input beat is registered in the input stage, its result beat in the result stage.
// Throughput: one input beat per cycle while the output is free and no write is in progress;
// a local write holds off input while its 2*(NODES-1)+1 result beats pass the single result stage after the read.
// Reset: valid, pending and written flags clear at once; no clearing pass.
// ----------------------------------------------------------------------------
module coherence_node_controller #(
	parameter int NODES      = 4,
	parameter int BLOCKS     = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [coh_pkg::NODE_W-1:0]          cfg_wdata,   // node_number
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [coh_pkg::IN_TDATA_W-1:0]      s_tdata,     // block, value, source_node
	input  logic [coh_pkg::MODE_W-1:0]          s_tuser,     // mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [coh_pkg::OUT_TDATA_W-1:0]     m_tdata,     // destination, result_block, result_value
	output logic [coh_pkg::OUT_TUSER_W-1:0]     m_tuser,     // out_kind, message_type
	output logic                                m_tlast
);

	localparam int DEPTH = (BLOCKS < (1 << coh_pkg::BLOCK_W)) ? BLOCKS : (1 << coh_pkg::BLOCK_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = ($clog2(NODES + 2) > coh_pkg::NODE_W) ? $clog2(NODES + 2)
		: coh_pkg::NODE_W;

	localparam logic [CW-1:0] NODES_C = CW'(NODES);
	localparam logic [CW-1:0] ONE_C   = CW'(1);
	localparam logic [CW-1:0] TWO_C   = CW'(2);

	logic [coh_pkg::NODE_W-1:0]  node_q;
	logic [coh_pkg::NODE_W-1:0]  me;
	logic [CW-1:0]               me_c;
	logic [CW-1:0]               first_peer;

	logic                        valid_s1;
	coh_pkg::mode_t              mode_s1;
	logic [coh_pkg::BLOCK_W-1:0] blk_s1;
	logic [coh_pkg::VALUE_W-1:0] value_s1;
	logic [coh_pkg::NODE_W-1:0]  src_s1;

	coh_pkg::seq_t               seq_q;
	logic [CW-1:0]               peer_q;
	logic [CW-1:0]               peer_inc;
	logic [CW-1:0]               peer_next;

	logic [DEPTH-1:0]            valid_q;
	logic [DEPTH-1:0]            pend_q;

	logic                        out_valid_q;
	coh_pkg::result_t            out_q;

	logic                        in_fire;
	logic [AW-1:0]               addr;
	logic                        blk_ok;
	logic                        src_ok;
	logic [coh_pkg::NODE_W-1:0]  rd_owner;
	logic [DATA_WIDTH-1:0]       rd_data;
	logic [coh_pkg::VALUE_W-1:0] data_out;
	logic [DATA_WIDTH-1:0]       val_dw;

	logic                        emit;
	logic                        last_seq;
	coh_pkg::result_t            res;
	logic                        wr_req;
	logic [coh_pkg::NODE_W-1:0]  wr_owner;
	logic [DATA_WIDTH-1:0]       wr_data;
	logic                        set_valid;
	logic                        clr_valid;
	logic                        set_pend;
	logic                        clr_pend;
	logic                        out_free;
	logic                        step_ok;
	logic                        commit;
	logic                        advance;

	always_comb begin
		if (node_q == '0) begin
			me = coh_pkg::NODE_W'(1);
		end else if (CW'(node_q) > NODES_C) begin
			me = coh_pkg::NODE_W'(NODES);
		end else begin
			me = node_q;
		end
		me_c       = CW'(me);
		first_peer = (me_c == ONE_C) ? TWO_C : ONE_C;
		peer_inc   = peer_q + ONE_C;
		peer_next  = (peer_inc == me_c) ? peer_inc + ONE_C : peer_inc;
	end

	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= coh_pkg::RESET_NODE;
		end else if (cfg_we) begin
			node_q <= cfg_wdata;
		end
	end

	coh_store #(
		.DEPTH      (DEPTH),
		.AW         (AW),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_fire),
		.rd_addr  (s_tdata[AW-1:0]),
		.wr_en    (commit && wr_req),
		.wr_addr  (addr),
		.wr_owner (wr_owner),
		.wr_data  (wr_data),
		.rd_owner (rd_owner),
		.rd_data  (rd_data)
	);

	assign addr     = blk_s1[AW-1:0];
	assign blk_ok   = ({{(32 - coh_pkg::BLOCK_W){1'b0}}, blk_s1} < 32'(BLOCKS));
	assign src_ok   = (src_s1 != '0) && (CW'(src_s1) <= NODES_C);
	assign data_out = coh_pkg::VALUE_W'(rd_data);
	assign val_dw   = DATA_WIDTH'(value_s1);

	always_comb begin
		emit      = 1'b0;
		last_seq  = 1'b1;
		res       = '0;
		res.blk   = blk_s1;
		res.last  = 1'b1;
		wr_req    = 1'b0;
		wr_owner  = rd_owner;
		wr_data   = rd_data;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		set_pend  = 1'b0;
		clr_pend  = 1'b0;
		if (blk_ok) begin
			unique case (mode_s1)
				coh_pkg::MODE_READ: begin
					emit = 1'b1;
					if (valid_q[addr] || (rd_owner == me)) begin
						res.kind  = coh_pkg::KIND_READ_DONE;
						res.value = data_out;
					end else begin
						res.kind = coh_pkg::KIND_MSG;
						res.msg  = coh_pkg::MSG_FETCH_REQ;
						res.dest = rd_owner;
						set_pend = 1'b1;
					end
				end
				coh_pkg::MODE_WRITE: begin
					emit = 1'b1;
					unique case (seq_q)
						coh_pkg::SEQ_INVAL: begin
							last_seq = 1'b0;
							res.kind = coh_pkg::KIND_MSG;
							res.msg  = coh_pkg::MSG_INVAL;
							res.dest = coh_pkg::NODE_W'(peer_q);
							res.last = 1'b0;
						end
						coh_pkg::SEQ_CLAIM: begin
							last_seq = 1'b0;
							res.kind = coh_pkg::KIND_MSG;
							res.msg  = coh_pkg::MSG_CLAIM;
							res.dest = coh_pkg::NODE_W'(peer_q);
							res.last = 1'b0;
						end
						default: begin
							res.kind  = coh_pkg::KIND_WRITE_DONE;
							res.value = coh_pkg::VALUE_W'(val_dw);
							wr_req    = 1'b1;
							wr_owner  = me;
							wr_data   = val_dw;
							set_valid = 1'b1;
						end
					endcase
				end
				coh_pkg::MODE_INVAL: begin
					clr_valid = 1'b1;
				end
				coh_pkg::MODE_FETCH_REQ: begin
					if (src_ok) begin
						emit      = 1'b1;
						res.kind  = coh_pkg::KIND_MSG;
						res.msg   = coh_pkg::MSG_FETCH_RSP;
						res.dest  = src_s1;
						res.value = data_out;
					end
				end
				coh_pkg::MODE_FETCH_RSP: begin
					wr_req    = 1'b1;
					wr_data   = val_dw;
					set_valid = 1'b1;
					if (pend_q[addr]) begin
						emit      = 1'b1;
						clr_pend  = 1'b1;
						res.kind  = coh_pkg::KIND_READ_DONE;
						res.value = coh_pkg::VALUE_W'(val_dw);
					end
				end
				coh_pkg::MODE_CLAIM: begin
					if (src_ok) begin
						wr_req   = 1'b1;
						wr_owner = src_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign step_ok  = valid_s1 && (!emit || out_free);
	assign commit   = step_ok && last_seq;
	assign advance  = step_ok && !last_seq;
	assign s_tready = !valid_s1 || commit;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1  <= coh_pkg::mode_t'(s_tuser);
			blk_s1   <= s_tdata[coh_pkg::BLOCK_W-1:0];
			value_s1 <= s_tdata[coh_pkg::BLOCK_W +: coh_pkg::VALUE_W];
			src_s1   <= s_tdata[coh_pkg::BLOCK_W + coh_pkg::VALUE_W +: coh_pkg::NODE_W];
		end
		if (step_ok && emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			seq_q       <= coh_pkg::SEQ_INVAL;
			peer_q      <= ONE_C;
			valid_q     <= '0;
			pend_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
				seq_q    <= coh_pkg::SEQ_INVAL;
				peer_q   <= first_peer;
			end else if (commit) begin
				valid_s1 <= 1'b0;
			end else if (advance) begin
				if (peer_next > NODES_C) begin
					peer_q <= first_peer;
					seq_q  <= (seq_q == coh_pkg::SEQ_INVAL) ? coh_pkg::SEQ_CLAIM
						: coh_pkg::SEQ_LAST;
				end else begin
					peer_q <= peer_next;
				end
			end
			if (commit) begin
				if (set_valid) begin
					valid_q[addr] <= 1'b1;
				end else if (clr_valid) begin
					valid_q[addr] <= 1'b0;
				end
				if (set_pend) begin
					pend_q[addr] <= 1'b1;
				end else if (clr_pend) begin
					pend_q[addr] <= 1'b0;
				end
			end
			if (step_ok && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{coh_pkg::OUT_PAD_W{1'b0}}, out_q.value, out_q.blk, out_q.dest};
	assign m_tuser  = {out_q.msg, out_q.kind};
	assign m_tlast  = out_q.last;

	// A write's broadcast holds off new input until its completion beat.
	a_write_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (mode_s1 == coh_pkg::MODE_WRITE) && (seq_q != coh_pkg::SEQ_LAST)
		|-> !s_tready)
		else $error("input accepted during a write broadcast");

	// A write completion is always the final beat of its item.
	a_write_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == coh_pkg::KIND_WRITE_DONE) |-> out_q.last)
		else $error("write completion without last");

	// Broadcast messages never go to this node itself.
	a_no_self_broadcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == coh_pkg::KIND_MSG)
		&& ((out_q.msg == coh_pkg::MSG_INVAL) || (out_q.msg == coh_pkg::MSG_CLAIM))
		|-> (out_q.dest != me))
		else $error("broadcast addressed to own node");

endmodule

// ===== rtl/core/coh_store.sv =====
// ----------------------------------------------------------------------------
// coh_store: block data and owner memory
// Synchronous memory with a registered read, a same-edge write bypass,
// and per-entry written flags so that unwritten entries read as reset values.
// ----------------------------------------------------------------------------
module coh_store #(
	parameter int DEPTH      = 8,
	parameter int AW         = 3,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [coh_pkg::NODE_W-1:0]  wr_owner,
	input  logic [DATA_WIDTH-1:0]       wr_data,
	output logic [coh_pkg::NODE_W-1:0]  rd_owner,
	output logic [DATA_WIDTH-1:0]       rd_data
);

	localparam int WORD_W = coh_pkg::NODE_W + DATA_WIDTH;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_word_q;
	logic [WORD_W-1:0] byp_word_q;
	logic [WORD_W-1:0] word;
	logic [AW-1:0]     rd_addr_q;
	logic              byp_q;
	logic [DEPTH-1:0]  written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= {wr_owner, wr_data};
		end
		if (rd_en) begin
			rd_word_q  <= mem_q[rd_addr];
			rd_addr_q  <= rd_addr;
			byp_word_q <= {wr_owner, wr_data};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			byp_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				byp_q <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	always_comb begin
		word = byp_q ? byp_word_q : rd_word_q;
		if (written_q[rd_addr_q]) begin
			rd_owner = word[WORD_W-1 -: coh_pkg::NODE_W];
			rd_data  = word[DATA_WIDTH-1:0];
		end else begin
			rd_owner = coh_pkg::RESET_OWNER;
			rd_data  = '0;
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: coherence node controller
// Tracks this node's block table, owners, pending reads and identity, and from
// them predicts every message and completion that each accepted input beat
// causes. Directed cases come first, then random coherence traffic over
// several node identities, with idle gaps on both sides of the stream in all but the last three segments.
// ----------------------------------------------------------------------------
module testbench;
	import coh_pkg::*;

	localparam int NODES         = 4;
	localparam int BLOCKS        = 8;
	localparam int SEGMENT_ITEMS = 40;
	localparam int STALL_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;

	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;

	localparam logic [NODE_W-1:0] NODE_SETTINGS [9] = '{4, 2, 0, 7, 3, 5, 1, 6, 4};

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [NODE_W-1:0]      cfg_wdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;     // block, value, source_node
	logic [MODE_W-1:0]      s_tuser;     // mode
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;     // destination, result_block, result_value
	logic [OUT_TUSER_W-1:0] m_tuser;     // out_kind, message_type
	logic                   m_tlast;

	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;

	result_t seen_beat;

	class directory_tracker;
		logic               block_valid [BLOCKS];
		logic [VALUE_W-1:0] block_data [BLOCKS];
		logic [NODE_W-1:0]  block_owner [BLOCKS];
		logic               read_pending [BLOCKS];
		logic [NODE_W-1:0]  node_id;
		result_t            awaited_beats [$];
		int                 mismatches;

		function void clear_state();
			for (int i = 0; i < BLOCKS; i++) begin
				block_valid[i]  = 1'b0;
				block_data[i]   = '0;
				block_owner[i]  = RESET_OWNER;
				read_pending[i] = 1'b0;
			end
			node_id = RESET_NODE;
			awaited_beats.delete();
			mismatches = 0;
		endfunction

		function logic [NODE_W-1:0] self_node();
			if (node_id == 0) return NODE_W'(1);
			if (node_id > NODES) return NODE_W'(NODES);
			return node_id;
		endfunction

		function void await_beat(kind_t kind, msg_t msg, logic [NODE_W-1:0] dest,
				logic [BLOCK_W-1:0] blk, logic [VALUE_W-1:0] value, logic last);
			result_t beat;
			beat.kind  = kind;
			beat.msg   = msg;
			beat.dest  = dest;
			beat.blk   = blk;
			beat.value = value;
			beat.last  = last;
			awaited_beats.push_back(beat);
		endfunction

		function void predict_request(logic [MODE_W-1:0] mode, logic [BLOCK_W-1:0] blk,
				logic [VALUE_W-1:0] value, logic [NODE_W-1:0] src);
			logic [NODE_W-1:0] me;
			logic              src_ok;
			me     = self_node();
			src_ok = (src >= 1) && (src <= NODES);
			case (mode)
				MODE_READ: begin
					if (block_valid[blk] || block_owner[blk] == me) begin
						await_beat(KIND_READ_DONE, MSG_INVAL, '0, blk, block_data[blk], 1'b1);
					end else begin
						read_pending[blk] = 1'b1;
						await_beat(KIND_MSG, MSG_FETCH_REQ, block_owner[blk], blk, '0, 1'b1);
					end
				end
				MODE_WRITE: begin
					for (int p = 1; p <= NODES; p++)
						if (p != me) await_beat(KIND_MSG, MSG_INVAL, NODE_W'(p), blk, '0, 1'b0);
					for (int p = 1; p <= NODES; p++)
						if (p != me) await_beat(KIND_MSG, MSG_CLAIM, NODE_W'(p), blk, '0, 1'b0);
					block_owner[blk] = me;
					block_data[blk]  = value;
					block_valid[blk] = 1'b1;
					await_beat(KIND_WRITE_DONE, MSG_INVAL, '0, blk, value, 1'b1);
				end
				MODE_INVAL: begin
					block_valid[blk] = 1'b0;
				end
				MODE_FETCH_REQ: begin
					if (src_ok) await_beat(KIND_MSG, MSG_FETCH_RSP, src, blk, block_data[blk], 1'b1);
				end
				MODE_FETCH_RSP: begin
					block_data[blk]  = value;
					block_valid[blk] = 1'b1;
					if (read_pending[blk]) begin
						read_pending[blk] = 1'b0;
						await_beat(KIND_READ_DONE, MSG_INVAL, '0, blk, value, 1'b1);
					end
				end
				MODE_CLAIM: begin
					if (src_ok) block_owner[blk] = src;
				end
				default: begin
				end
			endcase
		endfunction

		function void check_beat(result_t got);
			result_t want;
			if (awaited_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected beat kind=%0d msg=%0d dest=%0d block=%0d value=%h last=%b",
						$time, got.kind, got.msg, got.dest, got.blk, got.value, got.last);
				return;
			end
			want = awaited_beats.pop_front();
			if (got.kind !== want.kind || got.msg !== want.msg || got.dest !== want.dest ||
					got.blk !== want.blk || got.value !== want.value || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: beat mismatch", $time);
					$display("  expected kind=%0d msg=%0d dest=%0d block=%0d value=%h last=%b",
						want.kind, want.msg, want.dest, want.blk, want.value, want.last);
					$display("  actual   kind=%0d msg=%0d dest=%0d block=%0d value=%h last=%b",
						got.kind, got.msg, got.dest, got.blk, got.value, got.last);
				end
			end
		endfunction
	endclass

	directory_tracker tracker;

	coherence_node_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	assign seen_beat = {m_tuser[KIND_W-1:0], m_tuser[KIND_W+MSG_W-1:KIND_W],
		m_tdata[NODE_W-1:0], m_tdata[NODE_W+BLOCK_W-1:NODE_W],
		m_tdata[OUT_FIELDS_W-1:NODE_W+BLOCK_W], m_tlast};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_beat(seen_beat);
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
			else stall_cycles++;
		end
		$display("** coherence_node_controller: FAILED **");
		$finish;
	end

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return '0;
			1: return 32'h8000_0000;
			2: return 32'h7fff_ffff;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [BLOCK_W-1:0] blk,
			input logic [VALUE_W-1:0] value, input logic [NODE_W-1:0] src);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= IN_TDATA_W'({src, value, blk});
		do @(posedge clk); while (!s_tready);
		tracker.predict_request(mode, blk, value, src);
		if (mode <= MODE_CLAIM &&
				!((mode == MODE_FETCH_REQ || mode == MODE_CLAIM) && (src == 0 || src > NODES)))
			items_sent++;
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.awaited_beats.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_node(input logic [NODE_W-1:0] id);
		drain_and_settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= id;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.node_id = id;
	endtask

	task automatic random_traffic();
		logic [NODE_W-1:0]  me;
		logic [NODE_W-1:0]  peer;
		logic [NODE_W-1:0]  bad_src;
		logic [BLOCK_W-1:0] blk;
		int                 pick;
		me   = tracker.self_node();
		blk  = BLOCK_W'($urandom_range(BLOCKS - 1));
		pick = $urandom_range(99);
		do peer = NODE_W'($urandom_range(NODES, 1)); while (peer == me);
		bad_src = $urandom_range(1) ? NODE_W'(0) : NODE_W'($urandom_range(7, NODES + 1));
		if (pick < 30) begin
			send_beat(MODE_CLAIM, blk, $urandom, peer);
			send_beat(MODE_INVAL, blk, $urandom, NODE_W'($urandom_range(7)));
			send_beat(MODE_READ, blk, $urandom, NODE_W'($urandom_range(7)));
			if ($urandom_range(3) == 0)
				send_beat(MODE_READ, blk, $urandom, NODE_W'($urandom_range(7)));
			send_beat(MODE_FETCH_RSP, blk, pick_value(), peer);
			send_beat(MODE_READ, blk, $urandom, NODE_W'($urandom_range(7)));
		end else if (pick < 50) begin
			send_beat(MODE_WRITE, blk, pick_value(), NODE_W'($urandom_range(7)));
			if ($urandom_range(1)) send_beat(MODE_FETCH_REQ, blk, $urandom, peer);
		end else if (pick < 65) begin
			send_beat(MODE_READ, blk, $urandom, NODE_W'($urandom_range(7)));
		end else if (pick < 73) begin
			send_beat(MODE_FETCH_REQ, blk, $urandom, NODE_W'($urandom_range(NODES, 1)));
		end else if (pick < 80) begin
			send_beat(MODE_CLAIM, blk, $urandom, NODE_W'($urandom_range(NODES, 1)));
		end else if (pick < 86) begin
			send_beat(MODE_INVAL, blk, $urandom, NODE_W'($urandom_range(7)));
		end else if (pick < 93) begin
			send_beat(MODE_FETCH_RSP, blk, pick_value(), NODE_W'($urandom_range(7)));
		end else begin
			case ($urandom_range(3))
				0: send_beat(MODE_SPARE_A, blk, $urandom, NODE_W'($urandom_range(7)));
				1: send_beat(MODE_SPARE_B, blk, $urandom, NODE_W'($urandom_range(7)));
				2: send_beat(MODE_FETCH_REQ, blk, $urandom, bad_src);
				default: send_beat(MODE_CLAIM, blk, $urandom, bad_src);
			endcase
		end
	endtask

	initial begin
		tracker = new;
		tracker.clear_state();
		send_idle_pct = 32;
		recv_idle_pct = 59;
		items_sent    = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Node 1 owns every block after reset.
		send_beat(MODE_READ, 0, 32'h0, 0);
		send_beat(MODE_CLAIM, 1, 32'hffff_ffff, 3);
		send_beat(MODE_READ, 1, 32'h0, 7);
		send_beat(MODE_READ, 1, 32'h0, 0);
		send_beat(MODE_FETCH_RSP, 1, 32'h8000_0000, 3);
		send_beat(MODE_READ, 1, 32'h0, 2);
		send_beat(MODE_FETCH_RSP, 2, 32'h7fff_ffff, 4);
		send_beat(MODE_READ, 2, 32'h0, 1);
		send_beat(MODE_WRITE, 7, 32'hffff_ffff, 7);
		send_beat(MODE_INVAL, 7, 32'h0, 2);
		send_beat(MODE_READ, 7, 32'h0, 0);
		send_beat(MODE_FETCH_REQ, 7, 32'h0, 4);
		send_beat(MODE_FETCH_REQ, 7, 32'h0, 0);
		send_beat(MODE_FETCH_REQ, 7, 32'h0, 7);
		send_beat(MODE_CLAIM, 7, 32'h0, 0);
		send_beat(MODE_CLAIM, 7, 32'h0, 5);
		send_beat(MODE_CLAIM, 7, 32'h0, 2);
		send_beat(MODE_INVAL, 7, 32'h0, 0);
		send_beat(MODE_READ, 7, 32'h0, 3);
		send_beat(MODE_SPARE_A, 3, 32'h1234_5678, 1);
		send_beat(MODE_SPARE_B, 4, 32'hedcb_a987, 6);
		send_beat(MODE_WRITE, 0, 32'h0, 1);
		send_beat(MODE_FETCH_RSP, 0, 32'h5a5a_5a5a, 1);

		for (int seg = 0; seg < 9; seg++) begin
			if (seg == 3) begin
				send_idle_pct = 59;
				recv_idle_pct = 32;
			end else if (seg == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_node(NODE_SETTINGS[seg]);
			items_sent = 0;
			while (items_sent < SEGMENT_ITEMS) random_traffic();
		end

		drain_and_settle();
		if (tracker.mismatches == 0 && tracker.awaited_beats.size() == 0) begin
			$display("** coherence_node_controller: PASSED **");
		end else begin
			$display("** coherence_node_controller: FAILED **");
		end
		$finish;
	end
endmodule
